// ----- rtl/drn_pkg.sv -----
`default_nettype none

package drn_pkg;

	localparam int unsigned MAX_ITERATIONS = 8;
	localparam int unsigned STEP_W = 7;

	localparam logic [1:0] STATUS_CONVERGED = 2'd0;
	localparam logic [1:0] STATUS_INVALID = 2'd1;
	localparam logic [1:0] STATUS_CAP = 2'd2;

	localparam logic [10:0] EXP_TOO_LARGE = 11'h7FD;
	localparam logic [11:0] EXP_FOLD = 12'd2045;
	localparam logic [11:0] EXP_BIAS = 12'd1023;

	// 1.0 - 1e-9 and 1.0 + 1e-9, each rounded to double
	localparam logic [63:0] BAND_LO = 64'h3FEF_FFFF_FF76_8FA1;
	localparam logic [63:0] BAND_HI = 64'h3FF0_0000_0044_B830;

	localparam logic [2:0] FM_PARTS = 3'd4;
	localparam logic [2:0] FM_ROUND = 3'd5;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} fmul_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} fmul_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/drn_fmul.sv -----
`default_nettype none

module drn_fmul (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire drn_pkg::fmul_req_t req,
	output drn_pkg::fmul_rsp_t      rsp
);

	logic          run_q;
	logic [2:0]    cnt_q;
	logic          done_q;
	logic [52:0]   ma_q;
	logic [52:0]   mb_q;
	logic [11:0]   ex_q;
	logic [53:0]   pp_q;
	logic [105:0]  acc_q;
	logic [63:0]   res_q;

	logic [26:0]   op_a;
	logic [26:0]   op_b;
	logic [53:0]   prod;
	logic [105:0]  pp_sh;

	logic          norm;
	logic [52:0]   mant;
	logic          guard;
	logic          sticky;
	logic          up;
	logic [53:0]   rnd;
	logic [11:0]   rexp;
	logic [51:0]   rfrac;

	// partial product order: lo*lo, lo*hi, hi*lo, hi*hi
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin
				op_a = ma_q[26:0];
				op_b = mb_q[26:0];
			end
			2'd1: begin
				op_a = ma_q[26:0];
				op_b = {1'b0, mb_q[52:27]};
			end
			2'd2: begin
				op_a = {1'b0, ma_q[52:27]};
				op_b = mb_q[26:0];
			end
			default: begin
				op_a = {1'b0, ma_q[52:27]};
				op_b = {1'b0, mb_q[52:27]};
			end
		endcase
	end

	assign prod = {27'b0, op_a} * {27'b0, op_b};

	always_comb begin
		case (cnt_q)
			3'd1:       pp_sh = {52'b0, pp_q};
			3'd2, 3'd3: pp_sh = {25'b0, pp_q, 27'b0};
			default:    pp_sh = {pp_q[51:0], 54'b0};
		endcase
	end

	always_comb begin
		norm   = acc_q[105];
		mant   = norm ? acc_q[105:53] : acc_q[104:52];
		guard  = norm ? acc_q[52] : acc_q[51];
		sticky = norm ? (|acc_q[51:0]) : (|acc_q[50:0]);
		up     = guard & (sticky | mant[0]);
		rnd    = {1'b0, mant} + {53'b0, up};
		rexp   = ex_q - drn_pkg::EXP_BIAS + {11'b0, norm} + {11'b0, rnd[53]};
		rfrac  = rnd[53] ? 52'b0 : rnd[51:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= 3'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 3'd0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == drn_pkg::FM_ROUND) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ma_q  <= {1'b1, req.a[51:0]};
			mb_q  <= {1'b1, req.b[51:0]};
			ex_q  <= {1'b0, req.a[62:52]} + {1'b0, req.b[62:52]};
			acc_q <= '0;
		end else if (run_q) begin
			if (cnt_q < drn_pkg::FM_PARTS) begin
				pp_q <= prod;
			end
			if (cnt_q != 3'd0 && cnt_q <= drn_pkg::FM_PARTS) begin
				acc_q <= acc_q + pp_sh;
			end
			if (cnt_q == drn_pkg::FM_ROUND) begin
				res_q <= {1'b0, rexp[10:0], rfrac};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = res_q;

endmodule

`default_nettype wire

// ----- rtl/double_reciprocal_newton.sv -----
`default_nettype none

// reciprocal of a positive normal double by newton iteration
// input: a beat is taken at a rising edge with start high and busy low;
// operand_bits carries the double to invert
// output: done is high for one cycle with reciprocal_bits, status and
// steps_taken; the receiver cannot stall, the result must be taken then
// status 0 converged, 1 invalid or out-of-range input, 2 iteration cap
// invalid input: done follows one cycle after the beat, busy stays low
// valid input: 9 + 15 * n cycles for n correction steps, set by the
// shared multiplier (27 x 27 bits, four partial products, seven
// cycles per double multiply, two multiplies and one band check per step)
// busy is high from the cycle after a valid beat until done; one item at a
// time, the next beat may come in the cycle done is shown
// reset clears the sequencer and the strobe; no result is pending after it

module double_reciprocal_newton (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [63:0] operand_bits,
	output logic             done,
	output logic [63:0]      reciprocal_bits,
	output logic [1:0]       status,
	output logic [6:0]       steps_taken
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_WP   = 4'b0010,
		S_CHK  = 4'b0100,
		S_WX   = 4'b1000
	} state_t;

	state_t             state_q;
	logic               done_q;
	logic [63:0]        a_q;
	logic [63:0]        x_q;
	logic [63:0]        p_q;
	logic [6:0]         steps_q;
	logic [63:0]        rec_q;
	logic [1:0]         stat_q;
	logic [6:0]         steps_out_q;

	drn_pkg::fmul_req_t req;
	drn_pkg::fmul_rsp_t rsp;

	logic               accept;
	logic               invalid;
	logic [11:0]        x0_exp;
	logic [63:0]        x0;
	logic               outband;
	logic               at_cap;
	logic [53:0]        v;
	logic [52:0]        t_mant;
	logic [63:0]        t_bits;

	assign accept  = start && (state_q == S_IDLE);
	assign invalid = operand_bits[63] || (operand_bits[62:52] == 11'd0) ||
	                 (operand_bits[62:52] >= drn_pkg::EXP_TOO_LARGE);
	assign x0_exp  = drn_pkg::EXP_FOLD - {1'b0, operand_bits[62:52]};
	assign x0      = {1'b0, x0_exp[10:0], 52'b0};

	assign outband = (p_q < drn_pkg::BAND_LO) || (drn_pkg::BAND_HI < p_q);
	assign at_cap  = (steps_q == drn_pkg::STEP_W'(drn_pkg::MAX_ITERATIONS));

	// 2 - p for p in [0.5, 1)
	assign v      = 54'd0 - {1'b0, 1'b1, p_q[51:0]};
	assign t_mant = v[53:1] + {52'b0, v[0] & v[1]};
	assign t_bits = {1'b0, drn_pkg::EXP_BIAS[10:0], t_mant[51:0]};

	always_comb begin
		req.start = 1'b0;
		req.a     = a_q;
		req.b     = x_q;
		case (state_q)
			S_IDLE: begin
				req.start = accept && !invalid;
				req.a     = operand_bits;
				req.b     = x0;
			end
			S_CHK: begin
				req.start = outband && !at_cap;
				req.a     = x_q;
				req.b     = t_bits;
			end
			S_WX: begin
				req.start = rsp.done;
				req.a     = a_q;
				req.b     = rsp.res;
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	drn_fmul u_fmul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
			steps_q <= 7'd0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (invalid) begin
							done_q <= 1'b1;
						end else begin
							steps_q <= 7'd0;
							state_q <= S_WP;
						end
					end
				end
				S_WP: begin
					if (rsp.done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (!outband || at_cap) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						steps_q <= steps_q + 7'd1;
						state_q <= S_WX;
					end
				end
				S_WX: begin
					if (rsp.done) begin
						state_q <= S_WP;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					a_q <= operand_bits;
					x_q <= x0;
					if (invalid) begin
						rec_q       <= 64'd0;
						stat_q      <= drn_pkg::STATUS_INVALID;
						steps_out_q <= 7'd0;
					end
				end
			end
			S_WP: begin
				if (rsp.done) begin
					p_q <= rsp.res;
				end
			end
			S_CHK: begin
				if (!outband || at_cap) begin
					rec_q       <= x_q;
					stat_q      <= outband ? drn_pkg::STATUS_CAP : drn_pkg::STATUS_CONVERGED;
					steps_out_q <= steps_q;
				end
			end
			S_WX: begin
				if (rsp.done) begin
					x_q <= rsp.res;
				end
			end
			default: begin
				a_q <= a_q;
			end
		endcase
	end

	assign busy            = (state_q != S_IDLE);
	assign done            = done_q;
	assign reciprocal_bits = rec_q;
	assign status          = stat_q;
	assign steps_taken     = steps_out_q;

endmodule

`default_nettype wire

// ----- rtl/drn_checker.sv -----
`default_nettype none

module drn_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [63:0] operand_bits,
	input wire logic        done,
	input wire logic [63:0] reciprocal_bits,
	input wire logic [1:0]  status,
	input wire logic [6:0]  steps_taken
);

	logic bad_in;

	assign bad_in = operand_bits[63] || (operand_bits[62:52] == 11'd0) ||
	                (operand_bits[62:52] >= drn_pkg::EXP_TOO_LARGE);

	a_bad_fast: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && bad_in |=> done && status == drn_pkg::STATUS_INVALID)
		else $error("invalid operand not answered in one cycle");

	a_good_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !bad_in |=> busy && !done)
		else $error("valid operand did not start the iteration");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == drn_pkg::STATUS_INVALID |->
		reciprocal_bits == 64'd0 && steps_taken == 7'd0)
		else $error("error result not zero");

	a_cap_steps: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == drn_pkg::STATUS_CAP |->
		steps_taken == drn_pkg::STEP_W'(drn_pkg::MAX_ITERATIONS))
		else $error("cap flagged below the step limit");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> status != 2'd3 &&
		steps_taken <= drn_pkg::STEP_W'(drn_pkg::MAX_ITERATIONS))
		else $error("result fields out of range");

endmodule

bind double_reciprocal_newton drn_checker u_drn_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.operand_bits    (operand_bits),
	.done            (done),
	.reciprocal_bits (reciprocal_bits),
	.status          (status),
	.steps_taken     (steps_taken)
);

`default_nettype wire
